// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle as the trigger
`define VPA_ASSERT_NOW(lbl, clk, rst_n, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("assertion failed");

// condition holds in the cycle after the trigger
`define VPA_ASSERT_NEXT(lbl, clk, rst_n, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("assertion failed");

`endif

// ===== hdl/vpa_pkg.sv =====
// types and constants of the voice allocator
package vpa_pkg;

  localparam int NoteW  = 7;
  localparam int VelW   = 7;
  localparam int ChanW  = 3;
  localparam int StampW = 64;

  // command and action codes
  localparam logic CmdNoteOn  = 1'b0;
  localparam logic CmdNoteOff = 1'b1;
  localparam logic ActKeyOn   = 1'b0;
  localparam logic ActKeyOff  = 1'b1;

  // index slots carried along the cell chain
  localparam int SlotFree = 0;
  localparam int SlotRel  = 1;
  localparam int SlotBest = 2;
  localparam int SlotOff  = 3;
  localparam int NumSlots = 4;

  typedef struct packed {
    logic             command;
    logic [NoteW-1:0] note;
    logic [VelW-1:0]  velocity;
  } in_t;

  typedef struct packed {
    logic             action;
    logic [ChanW-1:0] channel;
    logic [NoteW-1:0] note_out;
    logic [VelW-1:0]  velocity_out;
  } out_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic              vld;
    logic              cmd;
    logic [NoteW-1:0]  note;
    logic [VelW-1:0]   vel;
    logic              free_hit;
    logic              rel_hit;
    logic              off_hit;
    logic [StampW-1:0] best_stamp;
  } tok_t;

  // write-back broadcast to all cells
  typedef struct packed {
    logic              en;
    logic              key_on;
    logic [NoteW-1:0]  note;
    logic [StampW-1:0] stamp;
  } cmt_t;

endpackage

// ===== hdl/vpa_cell.sv =====
// one voice cell: holds the voice state and advances the search token
module vpa_cell #(
  parameter int IdxW = 3,
  parameter int Idx  = 0
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  vpa_pkg::tok_t                          tok_i,
  input  logic [vpa_pkg::NumSlots-1:0][IdxW-1:0] idx_i,
  output vpa_pkg::tok_t                          tok_o,
  output logic [vpa_pkg::NumSlots-1:0][IdxW-1:0] idx_o,
  input  vpa_pkg::cmt_t                          cmt_i,
  input  logic [IdxW-1:0]                        cmt_idx_i
);
  import vpa_pkg::*;

  localparam logic [IdxW-1:0] MyIdx = IdxW'(Idx);

  logic              active_q;
  logic              rel_q;
  logic [NoteW-1:0]  note_q;
  logic [StampW-1:0] stamp_q;

  logic                           tok_vld_q;
  tok_t                           tok_d, tok_q;
  logic [NumSlots-1:0][IdxW-1:0]  idx_d, idx_q;

  always_comb begin
    tok_d = tok_i;
    idx_d = idx_i;
    if (!tok_i.free_hit && !active_q && !rel_q) begin
      tok_d.free_hit  = 1'b1;
      idx_d[SlotFree] = MyIdx;
    end
    if (!tok_i.rel_hit && rel_q) begin
      tok_d.rel_hit  = 1'b1;
      idx_d[SlotRel] = MyIdx;
    end
    // strict compare keeps the lowest index on equal stamps
    if (stamp_q < tok_i.best_stamp) begin
      tok_d.best_stamp = stamp_q;
      idx_d[SlotBest]  = MyIdx;
    end
    if (!tok_i.off_hit && active_q && (note_q == tok_i.note)) begin
      tok_d.off_hit  = 1'b1;
      idx_d[SlotOff] = MyIdx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      rel_q     <= 1'b0;
      note_q    <= '0;
      stamp_q   <= '0;
      tok_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= tok_i.vld;
      if (cmt_i.en && (cmt_idx_i == MyIdx)) begin
        if (cmt_i.key_on) begin
          active_q <= 1'b1;
          rel_q    <= 1'b0;
          note_q   <= cmt_i.note;
          stamp_q  <= cmt_i.stamp;
        end else begin
          active_q <= 1'b0;
          rel_q    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    idx_q <= idx_d;
  end

  always_comb begin
    tok_o     = tok_q;
    tok_o.vld = tok_vld_q;
    idx_o     = idx_q;
  end

endmodule

// ===== hdl/polyphonic_voice_allocator.sv =====
// Polyphonic voice allocator: maps note-on/note-off words to voice channels with
// oldest-note stealing. One event is handled at a time. An accepted word is sent
// as a search token down a chain of NUM_VOICES cells, one cell per cycle, each
// cell holding one voice; the token collects the lowest free voice, the lowest
// releasing voice, the oldest voice and the lowest active voice with the same
// note. When it leaves the last cell the choice is written back to the chosen
// cell and the result word is registered, then moved to the output register
// once that is free. The next word is taken once the result sits in the output
// register, or once an unmatched note-off has left the chain, so no new event
// is accepted before the last one is through. A result word held by a stalled
// output holds back the next result, and the input waits with it. An unmatched
// note-off produces no result word.
module polyphonic_voice_allocator #(
  parameter int NUM_VOICES = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  vpa_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output vpa_pkg::out_t  out_data_o
);
  import vpa_pkg::*;

  localparam int IdxW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

  logic              busy_q;
  logic              start_q;
  logic              pend_q;
  logic              out_valid_q;
  logic [StampW-1:0] stamp_q;
  in_t               item_q;
  out_t              res_q;
  out_t              out_q;

  tok_t                          tok [NUM_VOICES+1];
  logic [NumSlots-1:0][IdxW-1:0] idx [NUM_VOICES+1];

  tok_t                 last;
  logic [IdxW-1:0]      ch_sel;
  cmt_t                 cmt;
  logic [IdxW-1:0]      cmt_idx;
  logic                 emit;
  logic [IdxW+ChanW-1:0] ch_ext;
  out_t                 res_d;
  logic                 in_acc;
  logic                 out_free;

  assign in_ready_o  = !busy_q;
  assign in_acc      = in_valid_i && !busy_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    tok[0].vld        = start_q;
    tok[0].cmd        = item_q.command;
    tok[0].note       = item_q.note;
    tok[0].vel        = item_q.velocity;
    tok[0].free_hit   = 1'b0;
    tok[0].rel_hit    = 1'b0;
    tok[0].off_hit    = 1'b0;
    tok[0].best_stamp = '1;
    idx[0]            = '0;
  end

  for (genvar g = 0; g < NUM_VOICES; g++) begin : g_cell
    vpa_cell #(
      .IdxW(IdxW),
      .Idx (g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .tok_i    (tok[g]),
      .idx_i    (idx[g]),
      .tok_o    (tok[g+1]),
      .idx_o    (idx[g+1]),
      .cmt_i    (cmt),
      .cmt_idx_i(cmt_idx)
    );
  end

  assign last = tok[NUM_VOICES];

  // write-back and result from the token leaving the chain
  always_comb begin
    if (last.free_hit) begin
      ch_sel = idx[NUM_VOICES][SlotFree];
    end else if (last.rel_hit) begin
      ch_sel = idx[NUM_VOICES][SlotRel];
    end else begin
      ch_sel = idx[NUM_VOICES][SlotBest];
    end
    cmt.note  = last.note;
    cmt.stamp = stamp_q + StampW'(1);
    if (last.cmd == CmdNoteOn) begin
      emit       = 1'b1;
      cmt.key_on = 1'b1;
      cmt_idx    = ch_sel;
    end else begin
      emit       = last.off_hit;
      cmt.key_on = 1'b0;
      cmt_idx    = idx[NUM_VOICES][SlotOff];
    end
    cmt.en = last.vld && emit;
    ch_ext = {{ChanW{1'b0}}, cmt_idx};
    res_d.action       = (last.cmd == CmdNoteOn) ? ActKeyOn : ActKeyOff;
    res_d.channel      = ch_ext[ChanW-1:0];
    res_d.note_out     = last.note;
    res_d.velocity_out = (last.cmd == CmdNoteOn) ? last.vel : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      start_q     <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      stamp_q     <= '0;
    end else begin
      start_q <= in_acc;
      if (in_acc) begin
        busy_q <= 1'b1;
      end
      if (cmt.en && cmt.key_on) begin
        stamp_q <= cmt.stamp;
      end
      if (last.vld) begin
        if (emit) begin
          pend_q <= 1'b1;
        end else begin
          busy_q <= 1'b0;
        end
      end
      if (pend_q && out_free) begin
        out_valid_q <= 1'b1;
        pend_q      <= 1'b0;
        busy_q      <= 1'b0;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_data_i;
    end
    if (last.vld && emit) begin
      res_q <= res_d;
    end
    if (pend_q && out_free) begin
      out_q <= res_q;
    end
  end

endmodule

// ===== hdl/vpa_checker.sv =====
// port-level checks for the voice allocator, bound to the top level
module vpa_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input vpa_pkg::out_t out_data_o
);
  import vpa_pkg::*;

`include "assert_macros.svh"

  // a stalled result word stays put
  `VPA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `VPA_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(out_data_o))

  // key off never carries a velocity
  `VPA_ASSERT_NOW(a_off_vel, clk_i, rst_ni, out_valid_o && (out_data_o.action == ActKeyOff), out_data_o.velocity_out == '0)

  // one event in flight: ready drops right after a word is taken
  `VPA_ASSERT_NEXT(a_one_item, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

endmodule

bind polyphonic_voice_allocator vpa_checker u_vpa_checker (.*);
